FILE: src/tcc_pkg.sv
package tcc_pkg;
  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int SCREENS = 4;
  localparam int CELLS = ROWS * COLS;
  localparam int DEPTH = SCREENS * CELLS;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(CELLS + 1);
  localparam int SW = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int CW = $clog2(COLS);

  // Row of a cursor position by reciprocal multiplication: exact for any
  // position below 2**PW, since position times COLS stays below 2**NL_SHIFT.
  localparam int NL_SHIFT = PW + CW;
  localparam int NL_RECIP = (2 ** NL_SHIFT + COLS - 1) / COLS;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam logic [0:0] REG_COLOR = 1'b0;
  localparam logic [0:0] REG_TAB = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PUT, ST_CHK, ST_SCR_RD, ST_SCR_WAIT, ST_SCR_WR,
    ST_CLR, ST_RD_WAIT, ST_RD_DONE, ST_DONE
  } state_t;
endpackage

FILE: src/tcc_ram.sv
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/text_console_cursor_engine.sv
// Text console cursor engine: several virtual text screens with own cursors.
// Input: an item is accepted when start is high and busy is low. Operations
// are put character, clear screen, switch visible screen and read cell.
// Output: every item gives exactly one result, shown for one cycle while
// out_valid is high; the receiver cannot stall it and must take it then.
// Configuration: APB-style registers, attribute byte at 0x0, tab length at
// 0x4; the user must write them only while idle; the block does not check.
// Timing: all cells live in one single-port-write memory with a registered
// read, and one sequencer walks it; a clear writes one cell per cycle. A
// switch, an ignored zero code or an out-of-range item goes straight to
// the result, a read waits on the memory, a backspace or newline only
// moves the cursor, a character or each tab space is written, and all but
// a backspace check the screen end; a scroll copies each cell by read, wait
// and write. The next item can be taken in the cycle after the result.
// Reset: after rst_n the block runs a clearing pass over all
// SCREENS*ROWS*COLS cells (8000 cells here) with busy high; cursors and
// the visible screen return to zero and registers to their reset values.
module text_console_cursor_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_screen,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  output logic [2:0]  out_visible_screen,
  output logic [10:0] out_cursor_pos,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_color,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcc_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0] color_r;
  logic [4:0] tab_r;
  logic [PW-1:0] cur_r [SCREENS];
  logic [SW-1:0] vis_r, vis_nxt;
  logic [SW-1:0] scr_r, scr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] wpos;
  logic wcur;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic [7:0] rch_r, rch_nxt, rcol_r, rcol_nxt;
  logic st_r, st_nxt;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;
  logic [AW-1:0] base;
  logic [AW-1:0] src;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_COLOR: prdata = {24'd0, color_r};
      default:   prdata = {27'd0, tab_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= 8'd7;
      tab_r <= 5'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COLOR: color_r <= pwdata[7:0];
        default:   tab_r <= pwdata[4:0];
      endcase
    end
  end

  tcc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign base = AW'(scr_r) * AW'(CELLS);
  assign busy = (state_r != ST_IDLE);

  // Source cell of the scroll copy: the cell one row below, or the cell
  // itself on the bottom row, whose attribute is kept.
  assign src = (32'(idx_r) < (ROWS - 1) * COLS) ? base + idx_r + AW'(COLS)
                                                : base + idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      vis_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < SCREENS; i++) cur_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      vis_r <= vis_nxt;
      idx_r <= idx_nxt;
      if (wcur) cur_r[scr_r] <= wpos;
    end
  end

  always_ff @(posedge clk) begin
    scr_r <= scr_nxt;
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
    ch_r <= ch_nxt;
    rch_r <= rch_nxt;
    rcol_r <= rcol_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    vis_nxt = vis_r;
    scr_nxt = scr_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    ch_nxt = ch_r;
    rch_nxt = rch_r;
    rcol_nxt = rcol_r;
    st_nxt = st_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = {color_r, 8'd0};
    raddr = idx_r;
    wcur = 1'b0;
    wpos = pos_r;
    case (state_r)
      ST_INIT: begin
        we = 1'b1;
        wdata = {8'd7, 8'd0};
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(DEPTH - 1)) begin
          idx_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rch_nxt = '0;
          rcol_nxt = '0;
          st_nxt = 1'b0;
          scr_nxt = SW'(in_screen);
          ch_nxt = in_char_code;
          state_nxt = ST_DONE;
          if (in_opcode == OP_READ) begin
            if (32'(in_read_row) < ROWS && 32'(in_read_col) < COLS) begin
              idx_nxt = AW'(vis_r) * AW'(CELLS) + AW'(in_read_row) * AW'(COLS)
                        + AW'(in_read_col);
              state_nxt = ST_RD_WAIT;
            end
          end else if (32'(in_screen) >= SCREENS) begin
            st_nxt = 1'b1;
          end else if (in_opcode == OP_SWITCH) begin
            vis_nxt = SW'(in_screen);
          end else if (in_opcode == OP_CLEAR) begin
            idx_nxt = AW'(SW'(in_screen)) * AW'(CELLS);
            cnt_nxt = '0;
            state_nxt = ST_CLR;
          end else begin
            pos_nxt = cur_r[SW'(in_screen)];
            cnt_nxt = (in_char_code == CH_TAB) ?
                      ((tab_r > 5'd16) ? 5'd16 : tab_r) : 5'd1;
            if (in_char_code == 8'd0 ||
                (in_char_code == CH_TAB && tab_r == 5'd0)) state_nxt = ST_DONE;
            else state_nxt = ST_PUT;
          end
        end
      end
      ST_RD_WAIT: state_nxt = ST_RD_DONE;
      ST_RD_DONE: begin
        rch_nxt = rdata[7:0];
        rcol_nxt = rdata[15:8];
        state_nxt = ST_DONE;
      end
      ST_CLR: begin
        we = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == base + AW'(CELLS - 1)) begin
          wcur = 1'b1;
          wpos = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_PUT: begin
        state_nxt = ST_CHK;
        if (ch_r == CH_NL) begin
          pos_nxt = PW'((((48'(pos_r) * 48'(NL_RECIP)) >> NL_SHIFT) + 48'd1)
                        * 48'(COLS));
        end else if (ch_r == CH_BS) begin
          if (pos_r != '0) pos_nxt = pos_r - PW'(1);
          state_nxt = ST_DONE;
          wcur = 1'b1;
          wpos = (pos_r != '0) ? pos_r - PW'(1) : pos_r;
        end else begin
          we = 1'b1;
          waddr = base + AW'(pos_r);
          wdata = {color_r, (ch_r == CH_TAB) ? CH_SP : ch_r};
          pos_nxt = pos_r + PW'(1);
        end
      end
      ST_CHK: begin
        if (32'(pos_r) >= CELLS) begin
          pos_nxt = PW'((ROWS - 1) * COLS);
          idx_nxt = '0;
          state_nxt = ST_SCR_RD;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            wcur = 1'b1;
            state_nxt = ST_DONE;
          end else state_nxt = ST_PUT;
        end
      end
      ST_SCR_RD: begin
        raddr = src;
        state_nxt = ST_SCR_WAIT;
      end
      ST_SCR_WAIT: begin
        raddr = src;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we = 1'b1;
        waddr = base + idx_r;
        if (32'(idx_r) < (ROWS - 1) * COLS) begin
          wdata = rdata;
        end else begin
          wdata = {rdata[15:8], 8'd0};
        end
        idx_nxt = idx_r + AW'(1);
        state_nxt = ST_SCR_RD;
        if (idx_r == AW'(CELLS - 1)) begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            wcur = 1'b1;
            state_nxt = ST_DONE;
          end else state_nxt = ST_PUT;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = (state_r == ST_DONE);
  assign out_visible_screen = 3'(vis_r);
  assign out_cursor_pos = 11'(cur_r[vis_r]);
  assign out_cell_char = rch_r;
  assign out_cell_color = rcol_r;
  assign out_status = st_r;

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_status_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_cell_char == 8'd0 && out_cell_color == 8'd0))
    else $error("error result carries cell data");
`endif
endmodule
